>>> sv/viewport_resample_address_macros.svh
// Assertion macros shared by the checker of viewport_resample_address.
// Include guarded; holds macro definitions only.
`ifndef VIEWPORT_RESAMPLE_ADDRESS_MACROS_SVH
`define VIEWPORT_RESAMPLE_ADDRESS_MACROS_SVH
// Implication checked on every clock edge, masked while in reset.
`define VRA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: label failed");
// Implication whose consequent is checked in the next cycle.
`define VRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: label failed");
`endif

>>> sv/vra_pkg.sv
// Shared types and constants for the viewport resample address block.
// No dependencies.
package vra_pkg;

    localparam int ROW_W = 12;
    localparam int PLACE_W = 15;
    localparam int DRAWN_W = 15;
    localparam int SRC_W = 13;
    localparam int IDX_W = 24;
    localparam int CFG_IDX_W = 3;

    // signed working position width: covers border + pixel - place
    localparam int POS_W = 18;
    // quotient register width of the divider cells
    localparam int QUO_W = 28;
    // remainder width (holds up to twice the drawn size)
    localparam int REM_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLACE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLACE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRAWN_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRAWN_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR = 3'd6;

    // one axis worth of divide state moving down the cell chain
    typedef struct packed {
        logic [QUO_W-1:0] num;  // dividend shifting out, quotient shifting in
        logic [REM_W-1:0] rem;  // partial remainder
    } div_lane_t;

    // per-item sideband carried beside the divider lanes
    typedef struct packed {
        logic valid;
        logic covered;
        logic flip_x;
        logic flip_y;
    } item_ctl_t;

endpackage

>>> sv/viewport_resample_address.sv
// Top level: config registers, fold and scale chains, index multiply, output skid.
// Depends on vra_pkg, vra_div_chain.
//
//  channel   | dir | fields (low bit first)
//  s_axis    | in  | tdata: pixel_x[11:0], pixel_y[23:12]
//  m_axis    | out | tdata: source_x, source_y, source_index; tuser: covered
//  cfg       | in  | cfg_index[2:0], cfg_data[14:0]
//
// One beat per clock while the output register is empty or being taken; the path runs
// through stage 0, 16 fold cells, stage 1, 28 scale cells, stage 2 and the output register.
// The pipeline advances whenever the output register is empty or being taken.
// Reset clears all valid flags and config registers to their reset values.
module viewport_resample_address
#(
    parameter int BORDER_SIZE = 16,
    parameter int MAX_DIMENSION = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_x, pixel_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // source_x, source_y, source_index
    output logic        m_axis_tuser,   // covered
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    import vra_pkg::*;

    localparam int NSTEP = 16;

    // config registers
    logic signed [PLACE_W-1:0] place_x_reg, place_y_reg;
    logic [DRAWN_W-1:0] drawn_w_reg, drawn_h_reg;
    logic [SRC_W-1:0] src_w_reg, src_h_reg;
    logic mirror_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            place_x_reg <= '0;
            place_y_reg <= '0;
            drawn_w_reg <= DRAWN_W'(1);
            drawn_h_reg <= DRAWN_W'(1);
            src_w_reg <= SRC_W'(1);
            src_h_reg <= SRC_W'(1);
            mirror_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PLACE_X: place_x_reg <= cfg_data;
                REG_PLACE_Y: place_y_reg <= cfg_data;
                REG_DRAWN_W: drawn_w_reg <= cfg_data;
                REG_DRAWN_H: drawn_h_reg <= cfg_data;
                REG_SRC_W:   src_w_reg <= cfg_data[SRC_W-1:0];
                REG_SRC_H:   src_h_reg <= cfg_data[SRC_W-1:0];
                REG_MIRROR:  mirror_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [REM_W-1:0] dw, dh;
    logic [SRC_W-1:0] sw, sh;
    always_comb
    begin
        dw = (drawn_w_reg == '0) ? REM_W'(1) : REM_W'(drawn_w_reg);
        dh = (drawn_h_reg == '0) ? REM_W'(1) : REM_W'(drawn_h_reg);
        sw = (src_w_reg == '0) ? SRC_W'(1) :
             ((int'(src_w_reg) > MAX_DIMENSION) ? SRC_W'(MAX_DIMENSION) : src_w_reg);
        sh = (src_h_reg == '0) ? SRC_W'(1) :
             ((int'(src_h_reg) > MAX_DIMENSION) ? SRC_W'(MAX_DIMENSION) : src_h_reg);
    end

    // output skid and global advance
    logic out_valid_reg;
    logic adv;
    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // stage 0: relative positions
    logic signed [POS_W-1:0] rx0_reg, ry0_reg;
    logic v0_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v0_reg <= 1'b0;
        else if (adv) v0_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx0_reg <= POS_W'(BORDER_SIZE) + POS_W'(s_axis_tdata[11:0])
                       - POS_W'(place_x_reg);
            ry0_reg <= POS_W'(BORDER_SIZE) + POS_W'(s_axis_tdata[23:12])
                       - POS_W'(place_y_reg);
        end
    end

    // fold chain input: divide |rel| (biased) by drawn size
    // For negative rel, divide (-rel-1); floor tile = -q-1, rem = size-1-r.
    div_lane_t fin_x, fin_y;
    item_ctl_t fin_ctl;
    logic [POS_W-1:0] mx, my;
    always_comb
    begin
        mx = rx0_reg[POS_W-1] ? ~rx0_reg : rx0_reg;
        my = ry0_reg[POS_W-1] ? ~ry0_reg : ry0_reg;
        fin_x.num = {mx[NSTEP-1:0], {(QUO_W-NSTEP){1'b0}}};
        fin_x.rem = '0;
        fin_y.num = {my[NSTEP-1:0], {(QUO_W-NSTEP){1'b0}}};
        fin_y.rem = '0;
        fin_ctl.valid = v0_reg;
        fin_ctl.covered = mirror_reg ||
            (!rx0_reg[POS_W-1] && rx0_reg < $signed({2'b0, dw}) &&
             !ry0_reg[POS_W-1] && ry0_reg < $signed({2'b0, dh}));
        fin_ctl.flip_x = rx0_reg[POS_W-1];
        fin_ctl.flip_y = ry0_reg[POS_W-1];
    end

    div_lane_t fo_x, fo_y;
    item_ctl_t fo_ctl;
    logic [POS_W-1:0] fo_ax, fo_ay;
    vra_div_chain #(.NSTEP(NSTEP)) u_fold
    (
        .clk(clk), .rst_n(rst_n), .en(adv), .div_x(dw), .div_y(dh),
        .in_x(fin_x), .in_y(fin_y), .in_ctl(fin_ctl),
        .in_aux_x(rx0_reg), .in_aux_y(ry0_reg),
        .out_x(fo_x), .out_y(fo_y), .out_ctl(fo_ctl),
        .out_aux_x(fo_ax), .out_aux_y(fo_ay)
    );

    // stage 1: fold result, then w * source size
    logic [REM_W-1:0] wx, wy;
    logic odd_x, odd_y;
    logic [REM_W-1:0] wx_sel, wy_sel;
    always_comb
    begin
        // tile parity: tile = q (pos) or -q-1 (neg) -> odd iff q[0] ^ neg
        odd_x = fo_x.num[0] ^ fo_ctl.flip_x;
        odd_y = fo_y.num[0] ^ fo_ctl.flip_y;
        wx = fo_ctl.flip_x ? (dw - 1'b1 - fo_x.rem) : fo_x.rem;
        wy = fo_ctl.flip_y ? (dh - 1'b1 - fo_y.rem) : fo_y.rem;
        if (odd_x) wx = dw - 1'b1 - wx;
        if (odd_y) wy = dh - 1'b1 - wy;
        wx_sel = mirror_reg ? wx : fo_ax[REM_W-1:0];
        wy_sel = mirror_reg ? wy : fo_ay[REM_W-1:0];
    end

    logic [QUO_W-1:0] px1_reg, py1_reg;
    item_ctl_t c1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) c1_reg <= '0;
        else if (adv) c1_reg <= fo_ctl;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px1_reg <= QUO_W'(wx_sel) * QUO_W'(sw);
            py1_reg <= QUO_W'(wy_sel) * QUO_W'(sh);
        end
    end

    // scale chain: product / drawn size, QUO_W (28) quotient bits
    div_lane_t sin_x, sin_y;
    assign sin_x = '{num: px1_reg, rem: '0};
    assign sin_y = '{num: py1_reg, rem: '0};

    div_lane_t so_x, so_y;
    item_ctl_t so_ctl;
    logic [POS_W-1:0] so_ax, so_ay;
    vra_div_chain #(.NSTEP(QUO_W)) u_scale
    (
        .clk(clk), .rst_n(rst_n), .en(adv), .div_x(dw), .div_y(dh),
        .in_x(sin_x), .in_y(sin_y), .in_ctl(c1_reg),
        .in_aux_x('0), .in_aux_y('0),
        .out_x(so_x), .out_y(so_y), .out_ctl(so_ctl),
        .out_aux_x(so_ax), .out_aux_y(so_ay)
    );

    // stage 2: clamp, then index multiply
    logic [SRC_W-1:0] sx, sy;
    always_comb
    begin
        sx = (so_x.num >= QUO_W'(sw)) ? (sw - 1'b1) : so_x.num[SRC_W-1:0];
        sy = (so_y.num >= QUO_W'(sh)) ? (sh - 1'b1) : so_y.num[SRC_W-1:0];
        if (so_ax != so_ay) ;  // aux lanes unused past fold chain
    end

    logic [SRC_W-1:0] sx2_reg, sy2_reg;
    logic [IDX_W-1:0] row2_reg;
    item_ctl_t c2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) c2_reg <= '0;
        else if (adv) c2_reg <= so_ctl;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx2_reg <= sx;
            sy2_reg <= sy;
            row2_reg <= IDX_W'(sy) * IDX_W'(sw);
        end
    end

    // output register
    logic [47:0] odata_reg;
    logic ocov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (adv) out_valid_reg <= c2_reg.valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ocov_reg <= c2_reg.covered;
            if (c2_reg.covered)
                odata_reg <= {row2_reg + IDX_W'(sx2_reg), sy2_reg[ROW_W-1:0],
                              sx2_reg[ROW_W-1:0]};
            else
                odata_reg <= '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = odata_reg;
    assign m_axis_tuser = ocov_reg;
endmodule

>>> sv/vra_div_cell.sv
// One restoring-division step for both axes; a row of these forms the divider.
// Depends on vra_pkg.
module vra_div_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [vra_pkg::REM_W-1:0] div_x,
    input  logic [vra_pkg::REM_W-1:0] div_y,
    input  vra_pkg::div_lane_t   in_x,
    input  vra_pkg::div_lane_t   in_y,
    input  vra_pkg::item_ctl_t   in_ctl,
    input  logic [vra_pkg::POS_W-1:0] in_aux_x,
    input  logic [vra_pkg::POS_W-1:0] in_aux_y,
    output vra_pkg::div_lane_t   out_x,
    output vra_pkg::div_lane_t   out_y,
    output vra_pkg::item_ctl_t   out_ctl,
    output logic [vra_pkg::POS_W-1:0] out_aux_x,
    output logic [vra_pkg::POS_W-1:0] out_aux_y
);
    import vra_pkg::*;

    div_lane_t x_next, y_next;
    div_lane_t x_reg, y_reg;
    item_ctl_t ctl_reg;
    logic [POS_W-1:0] aux_x_reg, aux_y_reg;

    function automatic div_lane_t step(div_lane_t l, logic [REM_W-1:0] d);
        logic [REM_W-1:0] r;
        div_lane_t o;
        r = {l.rem[REM_W-2:0], l.num[QUO_W-1]};
        o.num = {l.num[QUO_W-2:0], 1'b0};
        if (r >= d)
        begin
            r = r - d;
            o.num[0] = 1'b1;
        end
        o.rem = r;
        return o;
    endfunction

    always_comb
    begin
        x_next = step(in_x, div_x);
        y_next = step(in_y, div_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            aux_x_reg <= in_aux_x;
            aux_y_reg <= in_aux_y;
        end
    end

    assign out_x = x_reg;
    assign out_y = y_reg;
    assign out_ctl = ctl_reg;
    assign out_aux_x = aux_x_reg;
    assign out_aux_y = aux_y_reg;
endmodule

>>> sv/vra_div_chain.sv
// Chain of division cells: NSTEP quotient bits, one per cell.
// Depends on vra_pkg and vra_div_cell.
module vra_div_chain
#(
    parameter int NSTEP = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [vra_pkg::REM_W-1:0] div_x,
    input  logic [vra_pkg::REM_W-1:0] div_y,
    input  vra_pkg::div_lane_t   in_x,
    input  vra_pkg::div_lane_t   in_y,
    input  vra_pkg::item_ctl_t   in_ctl,
    input  logic [vra_pkg::POS_W-1:0] in_aux_x,
    input  logic [vra_pkg::POS_W-1:0] in_aux_y,
    output vra_pkg::div_lane_t   out_x,
    output vra_pkg::div_lane_t   out_y,
    output vra_pkg::item_ctl_t   out_ctl,
    output logic [vra_pkg::POS_W-1:0] out_aux_x,
    output logic [vra_pkg::POS_W-1:0] out_aux_y
);
    import vra_pkg::*;

    div_lane_t lx [NSTEP+1];
    div_lane_t ly [NSTEP+1];
    item_ctl_t lc [NSTEP+1];
    logic [POS_W-1:0] ax [NSTEP+1];
    logic [POS_W-1:0] ay [NSTEP+1];

    assign lx[0] = in_x;
    assign ly[0] = in_y;
    assign lc[0] = in_ctl;
    assign ax[0] = in_aux_x;
    assign ay[0] = in_aux_y;

    for (genvar g = 0; g < NSTEP; g++)
    begin : g_cell
        vra_div_cell u_cell
        (
            .clk(clk), .rst_n(rst_n), .en(en),
            .div_x(div_x), .div_y(div_y),
            .in_x(lx[g]), .in_y(ly[g]), .in_ctl(lc[g]),
            .in_aux_x(ax[g]), .in_aux_y(ay[g]),
            .out_x(lx[g+1]), .out_y(ly[g+1]), .out_ctl(lc[g+1]),
            .out_aux_x(ax[g+1]), .out_aux_y(ay[g+1])
        );
    end

    assign out_x = lx[NSTEP];
    assign out_y = ly[NSTEP];
    assign out_ctl = lc[NSTEP];
    assign out_aux_x = ax[NSTEP];
    assign out_aux_y = ay[NSTEP];
endmodule

>>> sv/vra_checker.sv
// Port-level checker for viewport_resample_address, bound to the top level.
// Depends on viewport_resample_address_macros.svh.
`include "viewport_resample_address_macros.svh"
module vra_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        cfg_ready
);
    `VRA_ASSERT_IMP(a_uncov_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 48'd0)
    `VRA_ASSERT_IMP(a_ready_free, !m_axis_tvalid, s_axis_tready)
    `VRA_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `VRA_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready)
endmodule

bind viewport_resample_address vra_port_checker u_vra_port_checker
(
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_ready(cfg_ready)
);

>>> test/vra_checker.sv
// Checker for viewport_resample_address: watches the config, input and output channels,
// predicts each output beat and compares it field by field. Depends on vra_pkg.
module vra_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          beats_out,
    output int          covered_out
);
    import vra_pkg::*;

    localparam int BORDER = 16;
    localparam int MAX_DIM = 4096;

    typedef struct packed {
        logic        covered;
        logic [11:0] sx;
        logic [11:0] sy;
        logic [23:0] idx;
    } addr_t;

    addr_t addr_q[$];

    // shadow copy of the config registers
    logic signed [14:0] sh_place_x, sh_place_y;
    logic [14:0] sh_drawn_w, sh_drawn_h;
    logic [12:0] sh_src_w, sh_src_h;
    logic sh_mirror;

    function automatic longint fold_axis(longint rel, longint size);
        longint t, r;
        t = rel / size;
        r = rel % size;
        if (r < 0)
        begin
            t = t - 1;
            r = r + size;
        end
        if (t[0])
            r = size - 1 - r;
        return r;
    endfunction

    function automatic longint scale_axis(longint w, longint dsize, longint ssize);
        longint s;
        s = (w * ssize) / dsize;
        if (s >= ssize)
            s = ssize - 1;
        return s;
    endfunction

    function automatic addr_t map_pixel(logic [11:0] px, logic [11:0] py);
        addr_t a;
        longint dw, dh, sw, sh, rx, ry, wx, wy, sx, sy;
        dw = (sh_drawn_w == 0) ? 1 : sh_drawn_w;
        dh = (sh_drawn_h == 0) ? 1 : sh_drawn_h;
        sw = (sh_src_w == 0) ? 1 : (sh_src_w > MAX_DIM ? MAX_DIM : sh_src_w);
        sh = (sh_src_h == 0) ? 1 : (sh_src_h > MAX_DIM ? MAX_DIM : sh_src_h);
        rx = BORDER + longint'(px) - longint'(sh_place_x);
        ry = BORDER + longint'(py) - longint'(sh_place_y);
        a = '0;
        if (sh_mirror)
        begin
            wx = fold_axis(rx, dw);
            wy = fold_axis(ry, dh);
        end
        else
        begin
            wx = rx;
            wy = ry;
            if (wx < 0 || wx >= dw || wy < 0 || wy >= dh)
                return a;
        end
        sx = scale_axis(wx, dw, sw);
        sy = scale_axis(wy, dh, sh);
        a.covered = 1'b1;
        a.sx = sx[11:0];
        a.sy = sy[11:0];
        a.idx = 24'(sy * sw + sx);
        return a;
    endfunction

    assign pending = addr_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_place_x <= '0;
            sh_place_y <= '0;
            sh_drawn_w <= 15'd1;
            sh_drawn_h <= 15'd1;
            sh_src_w <= 13'd1;
            sh_src_h <= 13'd1;
            sh_mirror <= 1'b0;
            fail_count <= 0;
            beats_out <= 0;
            covered_out <= 0;
            addr_q.delete();
        end
        else
        begin
            // register write beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PLACE_X: sh_place_x <= cfg_data;
                    REG_PLACE_Y: sh_place_y <= cfg_data;
                    REG_DRAWN_W: sh_drawn_w <= cfg_data;
                    REG_DRAWN_H: sh_drawn_h <= cfg_data;
                    REG_SRC_W:   sh_src_w <= cfg_data[12:0];
                    REG_SRC_H:   sh_src_h <= cfg_data[12:0];
                    REG_MIRROR:  sh_mirror <= cfg_data[0];
                    default: ;
                endcase
            end
            // input beat: predict
            if (s_axis_tvalid && s_axis_tready)
                addr_q.push_back(map_pixel(s_axis_tdata[11:0], s_axis_tdata[23:12]));
            // output beat: compare with oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                addr_t got, want;
                got = {m_axis_tuser, m_axis_tdata[11:0], m_axis_tdata[23:12],
                       m_axis_tdata[47:24]};
                beats_out <= beats_out + 1;
                if (m_axis_tuser)
                    covered_out <= covered_out + 1;
                if (addr_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected output beat cov=%0d sx=%0d sy=%0d idx=%0d",
                                 got.covered, got.sx, got.sy, got.idx);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = addr_q.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("ERROR: exp cov=%0d sx=%0d sy=%0d idx=%0d",
                                     want.covered, want.sx, want.sy, want.idx);
                            $display("       got cov=%0d sx=%0d sy=%0d idx=%0d",
                                     got.covered, got.sx, got.sy, got.idx);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> test/tb_viewport_resample_address.sv
// Testbench top for viewport_resample_address: clock, reset, stimulus and verdict.
// Depends on vra_pkg, viewport_resample_address and vra_checker.
module tb_viewport_resample_address;
    import vra_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_data;
    int          fail_count, pending, beats_out, covered_out;
    int          idle_cycles = 0;
    int          pixels_sent;

    viewport_resample_address i_dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    vra_checker i_checker
    (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .beats_out(beats_out), .covered_out(covered_out)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog: cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("viewport_resample_address test failed");
            $finish;
        end
    end

    // output side: random stall per beat, with stall-free stretches
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [14:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_view(int px, int py, int dw, int dh, int sw, int sh, bit mir);
        write_reg(REG_PLACE_X, 15'(px));
        write_reg(REG_PLACE_Y, 15'(py));
        write_reg(REG_DRAWN_W, 15'(dw));
        write_reg(REG_DRAWN_H, 15'(dh));
        write_reg(REG_SRC_W, 15'(sw));
        write_reg(REG_SRC_H, 15'(sh));
        write_reg(REG_MIRROR, 15'(mir));
    endtask

    // one pixel beat; gap drawn per beat, sometimes zero for back-to-back runs
    task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit busy);
        int gap;
        gap = busy ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= {py, px};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        pixels_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random view; small sizes mostly, extremes sometimes
    task automatic random_view();
        int dw, dh, sw, sh;
        dw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 300);
        dh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 300);
        sw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 200);
        sh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 200);
        load_view($urandom_range(0, 3) == 0 ? $urandom_range(0, 32767) : $urandom_range(0, 400),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767) : $urandom_range(0, 400),
                  dw, dh, sw, sh, $urandom_range(0, 1));
    endtask

    initial
    begin
        int phase, k;
        bit busy;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixels_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: 1x1 image at the origin, border offsets pixel 0 out
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'hFFF, 12'hFFF, 0);
        drain();
        // single copy: inside, edges, outside above, to the right and below
        load_view(10, 20, 300, 200, 4096, 4096, 0);
        send_pixel(12'd0, 12'd0, 0);       // above the top edge of the drawn area
        send_pixel(12'd10, 12'd20, 0);
        send_pixel(12'd293, 12'd203, 0);   // last covered pixel
        send_pixel(12'd294, 12'd100, 0);   // right edge out
        send_pixel(12'd100, 12'd204, 0);   // bottom edge out
        send_pixel(12'hFFF, 12'hFFF, 0);
        drain();
        // negative placement, oversized and zero sizes
        load_view(-16384, 16383, 0, 32767, 8191, 0, 0);
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'hFFF, 12'd0, 0);
        send_pixel(12'h555, 12'hAAA, 0);
        drain();
        // mirror tiling with negative and odd tiles
        load_view(16383, -16384, 7, 5, 3, 4096, 1);
        send_pixel(12'd0, 12'd0, 1);
        send_pixel(12'd1, 12'd1, 1);
        send_pixel(12'hFFF, 12'hFFF, 1);
        send_pixel(12'hAAA, 12'h555, 1);
        drain();
        // mirror with drawn size larger than the source and tiny
        load_view(0, 0, 32767, 1, 1, 8191, 1);
        send_pixel(12'd7, 12'hFFF, 0);
        send_pixel(12'hFFF, 12'd3, 0);
        drain();

        // random phases
        for (phase = 0; phase < 25; phase++)
        begin
            random_view();
            busy = ($urandom_range(0, 2) == 0);
            for (k = 0; k < 30; k++)
                send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), busy);
            drain();
        end

        $display("sent %0d pixels over 30 register settings; %0d results, %0d covered",
                 pixels_sent, beats_out, covered_out);
        if (fail_count == 0 && pending == 0)
            $display("viewport_resample_address test passed");
        else
            $display("viewport_resample_address test failed");
        $finish;
    end
endmodule
